[sv/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg
// shared widths, defaults and item codes for the sorted table search block
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int KEY_W     = 32;
    localparam int SLOT_W    = 10;
    localparam int POS_W     = 11;
    localparam int DEPTH_DEF = 1024;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

endpackage

[sv/sts_ram.sv]
// ----------------------------------------------------------------------------
// sts_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int WIDTH = sts_pkg::KEY_W,
    parameter int DEPTH = sts_pkg::DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sorted_table_insert_search.sv]
// ----------------------------------------------------------------------------
// sorted_table_insert_search
// key table with bisection search for match position or insertion point
// ----------------------------------------------------------------------------
// input channel: i_valid / o_ready carry one item. a write item (op = 0)
// stores entry_value at entry_slot and gives no result; slots
// at or beyond TABLE_DEPTH are dropped. a search item (op = 1) bisects the
// first entry_count entries (saturated to TABLE_DEPTH) for search_key.
// output channel: o_valid / i_ready carry one position per search item.
// a search runs one table read per bisection level, then a final compare,
// then loads the output register; a zero count goes straight to that load.
// the single ram read port gives one table read and one key compare per
// cycle while the bisection runs, so the read port sets the search pace.
// o_ready is low while a search runs; write items are taken back to back.
// the output register lets a new item in while a result waits; a finished
// search holds in its last state until the output register is free.
// reset clears the sequencer and the output valid; table contents are
// undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_insert_search #(
    parameter int TABLE_DEPTH = sts_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_op,
    input  logic [sts_pkg::SLOT_W-1:0] i_entry_slot,
    input  logic [sts_pkg::KEY_W-1:0]  i_entry_value,
    input  logic [sts_pkg::KEY_W-1:0]  i_search_key,
    input  logic [sts_pkg::POS_W-1:0]  i_entry_count,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [sts_pkg::POS_W-1:0]  o_position
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW = sts_pkg::POS_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOP = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [sts_pkg::KEY_W-1:0]   r_key, n_key;
    logic [PW-1:0]               r_lo, n_lo;
    logic [PW-1:0]               r_hi, n_hi;
    logic [PW-1:0]               r_mid, n_mid;
    logic                        r_final, n_final;
    logic [PW-1:0]               r_pos, n_pos;
    logic                        r_out_valid, n_out_valid;
    logic [PW-1:0]               r_position, n_position;

    logic                        accept;
    logic [PW-1:0]               cnt_sat;
    logic                        ram_we;
    logic [AW-1:0]               ram_raddr;
    logic [sts_pkg::KEY_W-1:0]   ram_rdata;
    logic [PW-1:0]               lp_lo;
    logic [PW-1:0]               lp_hi;
    logic [PW:0]                 lp_sum;
    logic                        out_free;

    sts_ram #(
        .WIDTH (sts_pkg::KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_entry_slot)),
        .i_wdata (i_entry_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign cnt_sat  = (32'(i_entry_count) > TABLE_DEPTH) ? PW'(TABLE_DEPTH) : i_entry_count;
    assign out_free = !r_out_valid || i_ready;

    // one bisection level against the entry read last cycle
    always_comb begin
        lp_lo  = (r_key >= ram_rdata) ? r_mid : r_lo;
        lp_hi  = (r_key >= ram_rdata) ? r_hi : r_mid;
        lp_sum = {1'b0, lp_lo} + {1'b0, lp_hi};
    end

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_final     = r_final;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !i_ready;
        n_position  = r_position;
        ram_we      = 1'b0;
        ram_raddr   = AW'(r_lo);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == sts_pkg::OP_WRITE) begin
                        ram_we = (32'(i_entry_slot) < TABLE_DEPTH);
                    end else begin
                        n_key = i_search_key;
                        n_lo  = '0;
                        n_hi  = cnt_sat;
                        if (cnt_sat == '0) begin
                            n_pos   = '0;
                            n_state = S_DONE;
                        end else if (cnt_sat > PW'(1)) begin
                            n_mid     = cnt_sat >> 1;
                            ram_raddr = AW'(cnt_sat >> 1);
                            n_final   = 1'b0;
                            n_state   = S_LOOP;
                        end else begin
                            ram_raddr = '0;
                            n_final   = 1'b1;
                            n_state   = S_LOOP;
                        end
                    end
                end
            end
            S_LOOP: begin
                if (r_final) begin
                    n_pos   = (r_key <= ram_rdata) ? r_lo : r_hi;
                    n_state = S_DONE;
                end else begin
                    n_lo = lp_lo;
                    n_hi = lp_hi;
                    if ((lp_hi - lp_lo) > PW'(1)) begin
                        n_mid     = lp_sum[PW:1];
                        ram_raddr = AW'(lp_sum[PW:1]);
                    end else begin
                        ram_raddr = AW'(lp_lo);
                        n_final   = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_position  = r_pos;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_final    <= n_final;
        r_pos      <= n_pos;
        r_position <= n_position;
    end

    assign o_valid    = r_out_valid;
    assign o_position = r_position;

endmodule

[sv/sts_checker.sv]
// ----------------------------------------------------------------------------
// sts_checker
// port-level checks on the sorted table search block, bound to the top level
// ----------------------------------------------------------------------------
module sts_checker #(
    parameter int TABLE_DEPTH = sts_pkg::DEPTH_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_ready,
    input logic                      i_op,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic [sts_pkg::POS_W-1:0] o_position
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_position))
        else $error("result changed while stalled");

    // a search item closes the input until it is done
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_op == sts_pkg::OP_SEARCH) |=> !o_ready)
        else $error("input open during search");

    // a write item leaves the input open
    a_write_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_op == sts_pkg::OP_WRITE) |=> o_ready)
        else $error("input closed after write");

    // position never beyond the table
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_position) <= TABLE_DEPTH))
        else $error("position beyond table depth");

endmodule

bind sorted_table_insert_search sts_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_sts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .i_op       (i_op),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_position (o_position)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted key table search: writes keys into the
// table, fires searches over sorted and unsorted contents, and compares each
// returned position with a bisection predictor run on a shadow of the table
// ----------------------------------------------------------------------------
module tb_top;

    localparam int   KEY_W     = sts_pkg::KEY_W;
    localparam int   SLOT_W    = sts_pkg::SLOT_W;
    localparam int   POS_W     = sts_pkg::POS_W;
    localparam logic OP_WRITE  = sts_pkg::OP_WRITE;
    localparam logic OP_SEARCH = sts_pkg::OP_SEARCH;

    localparam int DEPTH        = sts_pkg::DEPTH_DEF;
    localparam int GAP_MAX      = 18;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int COUNT_MAX    = (1 << POS_W) - 1;
    localparam int FILL_SLOTS   = 320;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_op     = OP_WRITE;
    logic [SLOT_W-1:0] in_slot   = '0;
    logic [KEY_W-1:0]  in_value  = '0;
    logic [KEY_W-1:0]  in_key    = '0;
    logic [POS_W-1:0]  in_count  = '0;
    logic              out_ready = 1'b0;
    logic              dut_ready;
    logic              dut_valid;
    logic [POS_W-1:0]  dut_position;

    logic [KEY_W-1:0]  key_mem [DEPTH];
    bit                written [DEPTH];
    int                filled_prefix = 0;
    logic [POS_W-1:0]  pending_positions [$];

    int send_gap_max = GAP_MAX;
    int recv_gap_max = GAP_MAX;
    int err_count    = 0;
    int n_writes     = 0;
    int n_searches   = 0;
    int n_checked    = 0;

    sorted_table_insert_search #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_ready      (dut_ready),
        .i_op         (in_op),
        .i_entry_slot (in_slot),
        .i_entry_value(in_value),
        .i_search_key (in_key),
        .i_entry_count(in_count),
        .o_valid      (dut_valid),
        .i_ready      (out_ready),
        .o_position   (dut_position)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int draw_wait(int max_wait);
        if (max_wait == 0)
            return 0;
        return int'($urandom_range(max_wait, 0));
    endfunction

    function automatic logic [POS_W-1:0] bisect_position(logic [KEY_W-1:0] key,
                                                         logic [POS_W-1:0] count);
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        n = (count > DEPTH) ? DEPTH : count;
        if (n == 0)
            return '0;
        lo = 0;
        hi = n;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (key >= key_mem[mid])
                lo = mid;
            else
                hi = mid;
        end
        if (key <= key_mem[lo])
            return POS_W'(lo);
        return POS_W'(hi);
    endfunction

    // true when every entry the search reads has been written
    function automatic bit path_ok(logic [KEY_W-1:0] key, logic [POS_W-1:0] count);
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        n = (count > DEPTH) ? DEPTH : count;
        if (n == 0)
            return 1'b1;
        lo = 0;
        hi = n;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (!written[mid])
                return 1'b0;
            if (key >= key_mem[mid])
                lo = mid;
            else
                hi = mid;
        end
        return written[lo];
    endfunction

    function automatic logic [KEY_W-1:0] fill_value(int slot);
        return KEY_W'(slot) * 32'h0040_0000 + KEY_W'($urandom_range(32'h0020_0000));
    endfunction

    // counts from zero to past the table depth
    function automatic logic [POS_W-1:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return POS_W'($urandom_range(COUNT_MAX, DEPTH + 1));
        if (roll < 20)
            return POS_W'(DEPTH);
        if (roll < 27)
            return '0;
        if (roll < 40)
            return POS_W'($urandom_range(4, 1));
        if (roll < 70)
            return POS_W'($urandom_range(filled_prefix, 0));
        return POS_W'($urandom_range(DEPTH, 1));
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(logic [POS_W-1:0] count);
        int unsigned n;
        int unsigned roll;
        int unsigned idx;
        n = (count > DEPTH) ? DEPTH : count;
        roll = $urandom_range(99);
        if (n == 0)
            return $urandom();
        idx = $urandom_range(n - 1);
        if (!written[idx])
            return $urandom();
        if (roll < 35)
            return key_mem[idx];
        if (roll < 50)
            return key_mem[idx] + 1'b1;
        if (roll < 60)
            return key_mem[idx] - 1'b1;
        if (roll < 65)
            return '0;
        if (roll < 70)
            return '1;
        return $urandom();
    endfunction

    task automatic send_item(logic op, logic [SLOT_W-1:0] slot, logic [KEY_W-1:0] value,
                             logic [KEY_W-1:0] key, logic [POS_W-1:0] count);
        int gap;
        gap = draw_wait(send_gap_max);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_slot  <= slot;
        in_value <= value;
        in_key   <= key;
        in_count <= count;
        @(posedge clk);
        while (!dut_ready) @(posedge clk);
        if (op == OP_SEARCH) begin
            pending_positions.push_back(bisect_position(key, count));
            n_searches++;
        end else begin
            key_mem[slot] = value;
            written[slot] = 1'b1;
            while (filled_prefix < DEPTH && written[filled_prefix])
                filled_prefix++;
            n_writes++;
        end
    endtask

    task automatic send_write(logic [SLOT_W-1:0] slot, logic [KEY_W-1:0] value);
        send_item(OP_WRITE, slot, value, $urandom(), POS_W'($urandom()));
    endtask

    task automatic send_search(logic [KEY_W-1:0] key, logic [POS_W-1:0] count);
        send_item(OP_SEARCH, SLOT_W'($urandom()), $urandom(), key, count);
    endtask

    // searches stay on written entries, else fall back to the written prefix
    task automatic send_random_search();
        logic [POS_W-1:0] count;
        logic [KEY_W-1:0] key;
        bit               found;
        found = 1'b0;
        for (int t = 0; t < 16 && !found; t++) begin
            count = pick_count();
            key   = pick_key(count);
            found = path_ok(key, count);
        end
        if (!found) begin
            count = POS_W'($urandom_range(filled_prefix, 0));
            key   = pick_key(count);
        end
        send_search(key, count);
    endtask

    task automatic reroll_idling();
        send_gap_max = ($urandom_range(2) == 0) ? 0 : GAP_MAX;
        recv_gap_max = ($urandom_range(2) == 0) ? 0 : GAP_MAX;
    endtask

    // zero count before any write, then edge keys on a short table
    task automatic test_directed();
        send_search(32'h0000_1234, '0);
        send_search('1, '0);
        send_write(SLOT_W'(0), 32'h0000_0000);
        send_write(SLOT_W'(1), 32'h0000_0005);
        send_write(SLOT_W'(2), 32'h0000_000A);
        send_write(SLOT_W'(3), 32'h0000_0100);
        send_write(SLOT_W'(4), 32'h8000_0000);
        send_write(SLOT_W'(5), 32'hFFFF_FFF0);
        send_write(SLOT_W'(6), 32'hFFFF_FFFE);
        send_write(SLOT_W'(7), 32'hFFFF_FFFF);
        send_search(32'h0000_0000, POS_W'(1));
        send_search(32'h0000_0001, POS_W'(1));
        send_search(32'h0000_0000, POS_W'(8));
        send_search(32'h0000_0005, POS_W'(8));
        send_search(32'h0000_0006, POS_W'(8));
        send_search(32'h0000_000A, POS_W'(8));
        send_search(32'h7FFF_FFFF, POS_W'(8));
        send_search(32'h0000_0100, POS_W'(4));
        send_search(32'h0000_0101, POS_W'(4));
        send_search('1, POS_W'(8));
        send_search('1, POS_W'(7));
        send_search(32'hFFFF_FFFE, POS_W'(7));
        send_search(32'hFFFF_FFF1, POS_W'(6));
    endtask

    // sorted fill of the low table with searches as it grows
    task automatic test_table_fill();
        for (int i = 0; i < FILL_SLOTS; i++) begin
            if (i % 64 == 0)
                reroll_idling();
            send_write(SLOT_W'(i), fill_value(i));
            if (i % 8 == 7)
                send_random_search();
        end
    endtask

    // upper bisection path of a full table, then counts at and past the depth
    task automatic test_count_saturation();
        send_gap_max = GAP_MAX;
        recv_gap_max = GAP_MAX;
        send_write(SLOT_W'(0), '0);
        for (int s = DEPTH / 2; s < DEPTH - 1; s = s + (DEPTH - s) / 2)
            send_write(SLOT_W'(s), fill_value(s));
        send_write(SLOT_W'(DEPTH - 1), '1);
        send_search('0, POS_W'(DEPTH));
        send_search('0, POS_W'(COUNT_MAX));
        send_search('1, POS_W'(DEPTH));
        send_search('1, POS_W'(DEPTH + 1));
        send_search('1, POS_W'(COUNT_MAX));
        send_search(32'hFFFF_FFFE, POS_W'(DEPTH));
        send_search(key_mem[100], POS_W'(1100));
        send_search(key_mem[DEPTH - 2] + 1'b1, POS_W'(COUNT_MAX));
    endtask

    // writes keep the written prefix strictly increasing
    task automatic test_sorted_random();
        int unsigned      s;
        longint unsigned  lower;
        longint unsigned  upper;
        logic [KEY_W-1:0] v;
        for (int i = 0; i < 220; i++) begin
            if (i % 64 == 0)
                reroll_idling();
            if ($urandom_range(99) < 75) begin
                send_random_search();
            end else begin
                s = $urandom_range(filled_prefix - 2);
                lower = (s == 0) ? 64'd0 : longint'(key_mem[s - 1]) + 1;
                upper = longint'(key_mem[s + 1]) - 1;
                if (lower <= upper)
                    v = KEY_W'(lower + ($urandom() % (upper - lower + 1)));
                else
                    v = key_mem[s];
                send_write(SLOT_W'(s), v);
            end
        end
    endtask

    task automatic test_unsorted_table();
        for (int i = 0; i < 80; i++) begin
            if (i % 64 == 0)
                reroll_idling();
            if ($urandom_range(99) < 30)
                send_write(SLOT_W'($urandom()), $urandom());
            else
                send_random_search();
        end
    endtask

    initial begin : position_checker
        int               stall;
        logic [POS_W-1:0] want;
        while (!rst_n) @(posedge clk);
        forever begin
            stall = draw_wait(recv_gap_max);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!dut_valid) @(posedge clk);
            if (pending_positions.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual position %0d",
                         $time, dut_position);
                err_count++;
            end else begin
                want = pending_positions.pop_front();
                n_checked++;
                if (dut_position !== want) begin
                    $display("%0t: position mismatch, expected %0d, actual %0d",
                             $time, want, dut_position);
                    err_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout with %0d positions outstanding", pending_positions.size());
        $display("FAIL sorted_table_insert_search");
        $finish;
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_table_fill();
        test_count_saturation();
        test_sorted_random();
        test_unsorted_table();
        in_valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d table writes and %0d searches, %0d positions checked, %0d errors",
                 n_writes, n_searches, n_checked, err_count);
        $display("counts from zero past table depth, sorted and unsorted contents");
        if (err_count == 0)
            $display("PASS sorted_table_insert_search");
        else
            $display("FAIL sorted_table_insert_search");
        $finish;
    end

endmodule
